// ===== hw/rtl/spims_pkg.sv =====
// Shared types and constants of the SPI master shift engine.
package spims_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned MaxBits = 32;
  localparam int unsigned CountW  = 6;
  localparam int unsigned BitIdxW = $clog2(DataW);
  localparam int unsigned HalfW   = 8;

  localparam logic [HalfW-1:0] HalfDefault = 8'd2;

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdRead  = 2'd1,
    CmdWrite = 2'd2,
    CmdRsvd  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KindIdle  = 2'd0,
    KindRead  = 2'd1,
    KindWrite = 2'd2
  } kind_e;

  typedef enum logic {
    CfgBitOrder   = 1'b0,
    CfgHalfPeriod = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic             sclk;
    logic             mosi;
    logic             busy;
    logic             done;
    logic [DataW-1:0] read_data;
  } res_t;

endpackage

// ===== hw/rtl/spi_master_shift_engine.sv =====
// Top level of the tick-driven SPI master shift engine.
//
// Each input beat is one tick of the serial interface: a command (plain tick,
// start read, start write), a bit count, the word to send and the sampled
// MISO level. Each accepted beat yields exactly one output beat with the SCLK
// and MOSI levels for that tick, the busy and done flags and the last read word.
// Commands that arrive while a transfer runs are ignored.
// The state update for a tick is one pass of logic into the output register, so
// one beat is taken every cycle unless the receiver stalls. When it stalls, the
// result waits in the output register; a new beat is accepted in the same cycle
// the waiting one is taken. Configuration writes (bit order, half period) take
// effect at once. The user must issue them only while no transfer runs and no
// result is pending; the block itself does not enforce this.
// Reset clears the engine to idle with SCLK and MOSI low, bit order MSB first
// and a half period of two ticks; no clearing pass is needed.
module spi_master_shift_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [spims_pkg::HalfW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic [spims_pkg::CountW-1:0]  bit_count_i,
  input  logic [spims_pkg::DataW-1:0]   write_data_i,
  input  logic                          miso_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          sclk_level_o,
  output logic                          mosi_level_o,
  output logic                          busy_res_o,
  output logic                          done_res_o,
  output logic [spims_pkg::DataW-1:0]   read_data_o
);
  import spims_pkg::*;

  logic  accept;
  logic  out_valid_q;
  res_t  res;
  res_t  res_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  spims_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .step_i       (accept),
    .command_i    (command_i),
    .bit_count_i  (bit_count_i),
    .write_data_i (write_data_i),
    .miso_level_i (miso_level_i),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sclk_level_o = res_q.sclk;
  assign mosi_level_o = res_q.mosi;
  assign busy_res_o   = res_q.busy;
  assign done_res_o   = res_q.done;
  assign read_data_o  = res_q.read_data;

endmodule

// ===== hw/rtl/spims_core.sv =====
// Per-tick state update of the shift engine and its configuration registers.
module spims_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [spims_pkg::HalfW-1:0]     cfg_wdata_i,
  input  logic                            step_i,
  input  logic [1:0]                      command_i,
  input  logic [spims_pkg::CountW-1:0]    bit_count_i,
  input  logic [spims_pkg::DataW-1:0]     write_data_i,
  input  logic                            miso_level_i,
  output spims_pkg::res_t                 res_o
);
  import spims_pkg::*;

  logic              order_cfg_q;
  logic [HalfW-1:0]  half_q;

  logic [DataW-1:0]  shift_q, shift_d;
  logic [CountW-1:0] bits_left_q, bits_left_d;
  logic [CountW-1:0] total_q, total_d;
  logic [HalfW-1:0]  tick_q, tick_d;
  logic              phase_q, phase_d;
  kind_e             kind_q, kind_d;
  logic              order_q, order_d;
  logic              mosi_q, mosi_d;
  logic [DataW-1:0]  rdata_q, rdata_d;

  logic [CountW-1:0]  start_bits;
  logic [BitIdxW-1:0] msb_idx;
  logic [BitIdxW-1:0] lsb_pos;
  logic               sclk;
  logic               done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_cfg_q <= 1'b0;
      half_q      <= HalfDefault;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgBitOrder:   order_cfg_q <= cfg_wdata_i[0];
        CfgHalfPeriod: half_q <= (cfg_wdata_i == '0) ? HalfDefault : cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  assign start_bits = (bit_count_i > CountW'(MaxBits)) ? CountW'(MaxBits) : bit_count_i;
  assign msb_idx    = BitIdxW'(bits_left_q - CountW'(1));
  assign lsb_pos    = BitIdxW'(total_q - bits_left_q);

  always_comb begin
    shift_d     = shift_q;
    bits_left_d = bits_left_q;
    total_d     = total_q;
    tick_d      = tick_q;
    phase_d     = phase_q;
    kind_d      = kind_q;
    order_d     = order_q;
    mosi_d      = mosi_q;
    rdata_d     = rdata_q;
    sclk        = 1'b0;
    done        = 1'b0;

    if (kind_q == KindIdle) begin
      if (command_i == CmdRead || command_i == CmdWrite) begin
        kind_d      = (command_i == CmdRead) ? KindRead : KindWrite;
        bits_left_d = start_bits;
        total_d     = start_bits;
        shift_d     = (command_i == CmdWrite) ? write_data_i : '0;
        order_d     = order_cfg_q;
        phase_d     = 1'b0;
        tick_d      = '0;
      end
    end else if (tick_q != '0) begin
      tick_d = tick_q - HalfW'(1);
      sclk   = phase_q;
    end else if (phase_q) begin
      phase_d = 1'b0;
      tick_d  = half_q - HalfW'(1);
    end else if (bits_left_q == '0) begin
      done = 1'b1;
      if (kind_q == KindRead) begin
        rdata_d = shift_q;
      end
      kind_d = KindIdle;
    end else begin
      if (kind_q == KindWrite) begin
        if (order_q) begin
          mosi_d  = shift_q[0];
          shift_d = shift_q >> 1;
        end else begin
          mosi_d = shift_q[msb_idx];
        end
        tick_d = half_q - HalfW'(1);
      end else begin
        // LSB-first reads place each bit at its final position directly.
        if (order_q) begin
          shift_d = shift_q | (DataW'(miso_level_i) << lsb_pos);
        end else begin
          shift_d = {shift_q[DataW-2:0], miso_level_i};
        end
        tick_d = '0;
      end
      bits_left_d = bits_left_q - CountW'(1);
      phase_d     = 1'b1;
      sclk        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      bits_left_q <= '0;
      total_q     <= '0;
      tick_q      <= '0;
      phase_q     <= 1'b0;
      kind_q      <= KindIdle;
      order_q     <= 1'b0;
      mosi_q      <= 1'b0;
      rdata_q     <= '0;
    end else if (step_i) begin
      shift_q     <= shift_d;
      bits_left_q <= bits_left_d;
      total_q     <= total_d;
      tick_q      <= tick_d;
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      order_q     <= order_d;
      mosi_q      <= mosi_d;
      rdata_q     <= rdata_d;
    end
  end

  assign res_o.sclk      = sclk;
  assign res_o.mosi      = mosi_d;
  assign res_o.busy      = (kind_d != KindIdle);
  assign res_o.done      = done;
  assign res_o.read_data = rdata_d;

endmodule

// ===== verif/spi_master_shift_engine_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench that drives SPI master ticks and compares every output beat.
module spi_master_shift_engine_test;
  import spims_pkg::*;

  localparam int unsigned RandomTicks = 360;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned NumPhases   = 8;

  typedef struct {
    cmd_e              command;
    logic [CountW-1:0] bit_count;
    logic [DataW-1:0]  write_data;
    logic              miso;
  } tick_t;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             cfg_we    = 1'b0;
  cfg_idx_e         cfg_index = CfgBitOrder;
  logic [HalfW-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             out_ready = 1'b0;
  tick_t            held      = '{CmdTick, '0, '0, 1'b0};

  logic             in_ready_o;
  logic             out_valid_o;
  logic             sclk_level_o;
  logic             mosi_level_o;
  logic             busy_res_o;
  logic             done_res_o;
  logic [DataW-1:0] read_data_o;

  tick_t       tick_q[$];
  res_t        pin_state_q[$];
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 73;

  // Shadow copy of the engine state and its two registers.
  logic [63:0]       word_sh    = '0;
  logic [CountW-1:0] bits_rem   = '0;
  logic [CountW-1:0] bits_total = '0;
  logic [HalfW-1:0]  hold_cnt   = '0;
  logic              sclk_ph    = 1'b0;
  kind_e             kind       = KindIdle;
  logic              order_lat  = 1'b0;
  logic              mosi_drv   = 1'b0;
  logic [DataW-1:0]  last_rd    = '0;
  logic              order_cfg  = 1'b0;
  logic [HalfW-1:0]  half_cfg   = HalfDefault;

  spi_master_shift_engine u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .command_i    (held.command),
    .bit_count_i  (held.bit_count),
    .write_data_i (held.write_data),
    .miso_level_i (held.miso),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .sclk_level_o (sclk_level_o),
    .mosi_level_o (mosi_level_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_data_o  (read_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Advances the shadow engine by one tick and returns the pin levels it drives.
  function automatic res_t advance_tick(tick_t t);
    res_t              r;
    logic [CountW-1:0] n;
    r.sclk = 1'b0;
    r.done = 1'b0;
    if (kind == KindIdle) begin
      if (t.command == CmdRead || t.command == CmdWrite) begin
        n = (t.bit_count > MaxBits) ? CountW'(MaxBits) : t.bit_count;
        kind       = (t.command == CmdRead) ? KindRead : KindWrite;
        bits_rem   = n;
        bits_total = n;
        word_sh    = (t.command == CmdWrite) ? {32'd0, t.write_data} : '0;
        order_lat  = order_cfg;
        sclk_ph    = 1'b0;
        hold_cnt   = '0;
      end
    end else if (hold_cnt != 0) begin
      hold_cnt = hold_cnt - 1'b1;
      r.sclk   = sclk_ph;
    end else if (sclk_ph) begin
      sclk_ph  = 1'b0;
      hold_cnt = half_cfg - 1'b1;
    end else if (bits_rem == 0) begin
      r.done = 1'b1;
      if (kind == KindRead) begin
        last_rd = word_sh[DataW-1:0];
      end
      kind = KindIdle;
    end else begin
      if (kind == KindWrite) begin
        if (order_lat) begin
          mosi_drv = word_sh[0];
          word_sh  = word_sh >> 1;
        end else begin
          mosi_drv = word_sh[bits_rem - 1'b1];
        end
        hold_cnt = half_cfg - 1'b1;
      end else begin
        // A read samples MISO on the rising edge and keeps SCLK high for one tick only.
        if (order_lat) begin
          word_sh = word_sh | (64'(t.miso) << (bits_total - bits_rem));
        end else begin
          word_sh = (word_sh << 1) | 64'(t.miso);
        end
        hold_cnt = '0;
      end
      bits_rem = bits_rem - 1'b1;
      sclk_ph  = 1'b1;
      r.sclk   = 1'b1;
    end
    r.mosi      = mosi_drv;
    r.busy      = (kind != KindIdle);
    r.read_data = last_rd;
    return r;
  endfunction

  function automatic tick_t rand_tick(cmd_e c);
    tick_t t;
    t = '{c, CountW'($urandom), $urandom, 1'($urandom)};
    return t;
  endfunction

  // Queues a start beat and enough further ticks to reach the finishing tick.
  function automatic int unsigned queue_transfer(cmd_e c, logic [CountW-1:0] n,
                                                 logic [DataW-1:0] data);
    int unsigned eff;
    int unsigned span;
    tick_t       t;
    eff  = (n > MaxBits) ? MaxBits : n;
    span = (c == CmdWrite) ? 2 + 2 * half_cfg * eff : 2 + (half_cfg + 1) * eff;
    t = '{c, n, data, 1'($urandom)};
    tick_q.push_back(t);
    for (int unsigned i = 1; i < span; i++) begin
      if (i == span - 1 && $urandom_range(4) == 0) begin
        // A start on the finishing tick must be ignored.
        t = rand_tick($urandom_range(1) ? CmdRead : CmdWrite);
      end else if ($urandom_range(9) == 0) begin
        t = rand_tick(cmd_e'($urandom_range(1, 3)));
      end else begin
        t = rand_tick(CmdTick);
      end
      tick_q.push_back(t);
    end
    return span;
  endfunction

  // Waits until every beat has gone through and the shadow engine is idle.
  // The check runs on the falling edge so that the driver's updates have settled.
  task automatic settle();
    bit busy_left;
    do begin
      while (tick_q.size() != 0 || in_valid || pin_state_q.size() != 0) begin
        @(negedge clk_i);
      end
      busy_left = (kind != KindIdle);
      if (busy_left) begin
        tick_q.push_back(rand_tick(CmdTick));
      end
    end while (busy_left);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [HalfW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgBitOrder) begin
      order_cfg = val[0];
    end else begin
      half_cfg = (val == 0) ? HalfDefault : val;
    end
  endtask

  task automatic run_phase(int unsigned budget, int unsigned max_count);
    int unsigned       made;
    logic [CountW-1:0] n;
    made = 0;
    while (made < budget) begin
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          tick_q.push_back(rand_tick($urandom_range(3) == 0 ? CmdRsvd : CmdTick));
          made++;
        end
      end
      n = ($urandom_range(19) == 0) ? CountW'($urandom_range(63))
                                    : CountW'($urandom_range(1, max_count));
      made += queue_transfer($urandom_range(1) ? CmdRead : CmdWrite, n, $urandom);
    end
  endtask

  // Sender side: one beat per handshake, with random gaps.
  always @(posedge clk_i) begin
    tick_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        pin_state_q.push_back(advance_tick(held));
      end
      if (!in_valid || in_ready_o) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = tick_q.pop_front();
          held     <= nxt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: checks each output beat against the oldest prediction.
  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (pin_state_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("unexpected output beat: sclk %0d mosi %0d busy %0d done %0d rd %08h",
                     sclk_level_o, mosi_level_o, busy_res_o, done_res_o, read_data_o);
          end
        end else begin
          want = pin_state_q.pop_front();
          if (sclk_level_o !== want.sclk || mosi_level_o !== want.mosi ||
              busy_res_o !== want.busy || done_res_o !== want.done ||
              read_data_o !== want.read_data) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("beat mismatch (exp/got): sclk %0d/%0d mosi %0d/%0d busy %0d/%0d",
                       want.sclk, sclk_level_o, want.mosi, mosi_level_o,
                       want.busy, busy_res_o);
              $display("  done %0d/%0d read_data %08h/%08h",
                       want.done, done_res_o, want.read_data, read_data_o);
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    automatic int unsigned order_plan[NumPhases] = '{1, 0, 1, 0, 1, 0, 1, 0};
    automatic int unsigned half_plan[NumPhases]  = '{1, 0, 3, 255, 255, 4, 1, 6};
    half_plan[5] = $urandom_range(1, 4);
    half_plan[7] = $urandom_range(1, 6);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset settings: MSB first, two ticks per level.
    void'(queue_transfer(CmdWrite, 6'd32, 32'hA5A5_5A5A));
    void'(queue_transfer(CmdWrite, 6'd1, 32'h0000_0001));
    void'(queue_transfer(CmdRead, 6'd1, '0));
    void'(queue_transfer(CmdRead, 6'd0, '0));
    void'(queue_transfer(CmdWrite, 6'd0, 32'hFFFF_FFFF));
    tick_q.push_back(rand_tick(CmdRsvd));
    tick_q.push_back(rand_tick(CmdTick));
    settle();
    // Bit counts above the limit, at one tick per level.
    write_reg(CfgHalfPeriod, 8'd1);
    void'(queue_transfer(CmdWrite, 6'd63, 32'hFFFF_FFFF));
    void'(queue_transfer(CmdRead, 6'd33, '0));
    settle();
    write_reg(CfgBitOrder, 8'hFF);
    void'(queue_transfer(CmdWrite, 6'd32, 32'h8000_0001));
    void'(queue_transfer(CmdRead, 6'd63, '0));
    settle();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      if (p == 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 36;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CfgBitOrder, (HalfW'($urandom) & 8'hFE) | HalfW'(order_plan[p]));
      write_reg(CfgHalfPeriod, HalfW'(half_plan[p]));
      // Slow clock settings get a single short transfer.
      if (half_cfg >= 128) begin
        void'(queue_transfer(CmdRead, 6'd1, '0));
      end else begin
        run_phase(RandomTicks / 6, 16);
      end
      settle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pin_state_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
